/* rtl/pcs_pkg.sv */
// Shared types, codes and register indexes of the pulse capture sequencer.
package pcs_pkg;

  localparam int unsigned CountW   = 32;
  localparam int unsigned SegCfgW  = 16;
  localparam int unsigned SegIdxW  = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CountW-1:0]  CycleCountRst      = '0;
  localparam logic [CountW-1:0]  ConfirmTimeoutRst  = '0;
  localparam logic [SegCfgW-1:0] DelaySegmentsRst   = SegCfgW'(1);
  localparam logic [SegCfgW-1:0] CaptureSegmentsRst = SegCfgW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CYCLE_COUNT      = 2'd0,
    CFG_CONFIRM_TIMEOUT  = 2'd1,
    CFG_DELAY_SEGMENTS   = 2'd2,
    CFG_CAPTURE_SEGMENTS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_TICK    = 2'd1,
    OP_CONFIRM = 2'd2,
    OP_SEG_END = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_DONE      = 3'd1,
    OUT_ABORTED   = 3'd2,
    OUT_NO_CAMERA = 3'd3,
    OUT_TIMEOUT   = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_SHUTTER = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CountW-1:0]  cycle_count;
    logic [CountW-1:0]  confirm_timeout_ms;
    logic [SegCfgW-1:0] delay_segments;
    logic [SegCfgW-1:0] capture_segments;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [CountW-1:0]  ms_left;
    logic [SegIdxW-1:0] ended_segment;
    logic [CountW-1:0]  completed_count;
  } state_t;

  typedef struct packed {
    logic               arm_and_fire;
    logic               start_shutter_timer;
    logic               load_segment;
    logic [SegIdxW-1:0] segment_index;
    logic               stop_shutter_timer;
    logic               release_outputs;
    outcome_e           outcome;
    logic [CountW-1:0]  cycles_done;
    logic               busy_res;
  } result_t;

endpackage

/* rtl/pulse_capture_sequencer_core.sv */
// Top level of the pulse capture sequencer: config registers, state and result register.
//
// The block runs a fixed number of laser-and-shutter cycles from a stream of
// events (start, millisecond tick, confirm edge, segment end). Each event is one
// request on the input channel (valid/ready) and produces exactly one result
// request on the output channel, carrying the action flags, the run outcome,
// the completed cycle count and the busy flag as seen after that event.
// The event is decoded and the sequencer state updated in the cycle it is
// accepted; its result appears on the output register in the following cycle.
// Throughput is one event per cycle while the output is taken, set by the single
// state register that every event reads and writes.
// The input is ready whenever the output register is empty or is being taken
// in the same cycle, so a stalled receiver holds exactly one finished result
// and back-pressures the input; nothing is dropped or repeated.
// Configuration registers are written through a plain write port with no wait
// and must only be written while no request is in flight.
// Reset clears the sequencer to idle with zero counts, loads the register
// defaults (zero cycles, timeout disabled, one delay and one capture segment)
// and empties the output register.
module pulse_capture_sequencer_core import pcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic                host_byte_pending_i,
  input  logic                camera_active_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                arm_and_fire_o,
  output logic                start_shutter_timer_o,
  output logic                load_segment_o,
  output logic [SegIdxW-1:0]  segment_index_o,
  output logic                stop_shutter_timer_o,
  output logic                release_outputs_o,
  output logic [2:0]          outcome_o,
  output logic [CountW-1:0]   cycles_done_o,
  output logic                busy_res_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    accept;

  // Input is taken whenever the single output slot is free or draining now.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration registers. The 16-bit segment counts keep the low data bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycle_count        <= CycleCountRst;
      cfg_q.confirm_timeout_ms <= ConfirmTimeoutRst;
      cfg_q.delay_segments     <= DelaySegmentsRst;
      cfg_q.capture_segments   <= CaptureSegmentsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CYCLE_COUNT:      cfg_q.cycle_count        <= cfg_wdata_i[CountW-1:0];
        CFG_CONFIRM_TIMEOUT:  cfg_q.confirm_timeout_ms <= cfg_wdata_i[CountW-1:0];
        CFG_DELAY_SEGMENTS:   cfg_q.delay_segments     <= cfg_wdata_i[SegCfgW-1:0];
        CFG_CAPTURE_SEGMENTS: cfg_q.capture_segments   <= cfg_wdata_i[SegCfgW-1:0];
        default: begin
        end
      endcase
    end
  end

  // One pass of event decode against the current state.
  pcs_step u_step (
    .cfg_i               (cfg_q),
    .state_i             (state_q),
    .opcode_i            (opcode_i),
    .host_byte_pending_i (host_byte_pending_i),
    .camera_active_i     (camera_active_i),
    .state_o             (state_d),
    .result_o            (res_d)
  );

  // Sequencer state and the registered result move together on each accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase           <= PH_IDLE;
      state_q.ms_left         <= '0;
      state_q.ended_segment   <= '0;
      state_q.completed_count <= '0;
      out_valid_q             <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload carries no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign arm_and_fire_o        = res_q.arm_and_fire;
  assign start_shutter_timer_o = res_q.start_shutter_timer;
  assign load_segment_o        = res_q.load_segment;
  assign segment_index_o       = res_q.segment_index;
  assign stop_shutter_timer_o  = res_q.stop_shutter_timer;
  assign release_outputs_o     = res_q.release_outputs;
  assign outcome_o             = res_q.outcome;
  assign cycles_done_o         = res_q.cycles_done;
  assign busy_res_o            = res_q.busy_res;

  // The held result always describes the current state.
  a_busy_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.busy_res == (state_q.phase != PH_IDLE)))
    else $error("busy flag disagrees with sequencer phase");

  a_count_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.cycles_done == state_q.completed_count))
    else $error("cycles_done disagrees with completed count");

  // A run end leaves the sequencer idle with a nonzero outcome.
  a_release_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.release_outputs) |->
      (!res_q.busy_res && res_q.outcome != OUT_NONE))
    else $error("release without idle state and outcome");

  // A segment load never loads segment zero and never ends the run.
  a_load_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.load_segment) |->
      (res_q.segment_index != '0 && !res_q.release_outputs &&
       state_q.phase == PH_SHUTTER))
    else $error("bad segment load result");

  // State only changes on an accepted request.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q))
    else $error("state changed without a request");

endmodule

/* rtl/pcs_step.sv */
// Next-state and result logic for one sequencer event.
module pcs_step import pcs_pkg::*; (
  input  cfg_t       cfg_i,
  input  state_t     state_i,
  input  logic [1:0] opcode_i,
  input  logic       host_byte_pending_i,
  input  logic       camera_active_i,
  output state_t     state_o,
  output result_t    result_o
);

  logic [SegIdxW-1:0] total_sum;
  logic [SegIdxW-1:0] total;
  logic [SegIdxW:0]   nxt;
  logic [CountW-1:0]  ms_dec;

  assign total_sum = {1'b0, cfg_i.delay_segments} + {1'b0, cfg_i.capture_segments};
  assign total     = (total_sum < SegIdxW'(2)) ? SegIdxW'(2) : total_sum;
  assign nxt       = {1'b0, state_i.ended_segment} + (SegIdxW+1)'(1);
  assign ms_dec    = state_i.ms_left - CountW'(1);

  always_comb begin
    logic              check;
    logic [CountW-1:0] cnt;
    check    = 1'b0;
    cnt      = state_i.completed_count;
    state_o  = state_i;
    result_o = '0;
    result_o.outcome = OUT_NONE;

    case (op_e'(opcode_i))
      OP_START: begin
        if (state_i.phase == PH_IDLE) begin
          cnt   = '0;
          check = 1'b1;
        end
      end
      OP_TICK: begin
        if (state_i.phase == PH_CONFIRM) begin
          if (host_byte_pending_i) begin
            result_o.release_outputs = 1'b1;
            result_o.outcome         = OUT_ABORTED;
            state_o.phase            = PH_IDLE;
          end else begin
            state_o.ms_left = ms_dec;
            if (ms_dec == '0 && cfg_i.confirm_timeout_ms != '0) begin
              result_o.release_outputs = 1'b1;
              result_o.outcome         = OUT_TIMEOUT;
              state_o.phase            = PH_IDLE;
            end
          end
        end
      end
      OP_CONFIRM: begin
        if (state_i.phase == PH_CONFIRM) begin
          result_o.start_shutter_timer = 1'b1;
          state_o.phase                = PH_SHUTTER;
          state_o.ended_segment        = '0;
        end
      end
      OP_SEG_END: begin
        if (state_i.phase == PH_SHUTTER) begin
          if (nxt >= {1'b0, total}) begin
            result_o.stop_shutter_timer = 1'b1;
            state_o.ended_segment       = '0;
            cnt                         = state_i.completed_count + CountW'(1);
            check                       = 1'b1;
          end else if (nxt >= (SegIdxW+1)'(2) && host_byte_pending_i) begin
            result_o.release_outputs = 1'b1;
            result_o.outcome         = OUT_ABORTED;
            state_o.phase            = PH_IDLE;
          end else begin
            result_o.load_segment  = 1'b1;
            result_o.segment_index = nxt[SegIdxW-1:0];
            state_o.ended_segment  = nxt[SegIdxW-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    // Check made before every cycle: finished, aborted, no camera, or go.
    if (check) begin
      if (cnt >= cfg_i.cycle_count) begin
        result_o.release_outputs = 1'b1;
        result_o.outcome         = OUT_DONE;
        state_o.phase            = PH_IDLE;
      end else if (host_byte_pending_i) begin
        result_o.release_outputs = 1'b1;
        result_o.outcome         = OUT_ABORTED;
        state_o.phase            = PH_IDLE;
      end else if (!camera_active_i) begin
        result_o.release_outputs = 1'b1;
        result_o.outcome         = OUT_NO_CAMERA;
        state_o.phase            = PH_IDLE;
      end else begin
        result_o.arm_and_fire = 1'b1;
        state_o.phase         = PH_CONFIRM;
        state_o.ms_left       = cfg_i.confirm_timeout_ms;
        state_o.ended_segment = '0;
      end
    end

    state_o.completed_count = cnt;
    result_o.cycles_done    = cnt;
    result_o.busy_res       = (state_o.phase != PH_IDLE);
  end

endmodule
